### design/first_fit_heap_allocator_defines.svh
// Assertion macros used by the heap allocator top level.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define FFHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
// Assert that an expression holds at every clock edge out of reset.
`define FFHA_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`endif

### design/ffha_pkg.sv
// Package with widths, status codes and controller types of the heap allocator.
package ffha_pkg;
    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEADER_BYTES = 24;
    localparam int ADDR_W = 20;
    localparam int SIZE_W = 16;
    localparam int STAT_W = 3;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_NULL    = 3'd1,
        ST_OOM     = 3'd2,
        ST_DOUBLE  = 3'd3,
        ST_UNKNOWN = 3'd4
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a request, clear index and running start
        logic rd;        // issue a memory read at the address chosen by rd_sel
        logic advance;   // add header and read entry length to the running start, index += 1
        logic mark;      // write the current entry with a new free mark
        logic mark_val;
        logic append;    // write a new entry at block_count
        logic merge_nxt; // entry index := cur + hdr + next, free
        logic merge_prv; // entry index-1 := prev + hdr + cur
        logic shift;     // copy entry index+1 to index, index += 1
        logic dec_count;
        logic set_back;  // index := index of the freed block (keep held entry)
        logic set_drop;  // shift start := index + 1 (index += 1)
        logic save_res;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free_req;
        logic zero_size;
        logic null_off;
        logic at_end;      // index >= block_count
        logic fit;         // read entry is free and large enough
        logic hit;         // running start + header == offset
        logic ent_free;    // read entry free mark
        logic can_append;
        logic has_next;    // index + 1 < block_count
        logic has_prev;    // index > 0
        logic shift_done;  // index + 1 >= block_count
    } stat_t;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_RD     = 14'b00000000000010,
        S_CHK    = 14'b00000000000100,
        S_APPEND = 14'b00000000001000,
        S_FMARK  = 14'b00000000010000,
        S_NRD    = 14'b00000000100000,
        S_NCHK   = 14'b00000001000000,
        S_SHRD   = 14'b00000010000000,
        S_SHWR   = 14'b00000100000000,
        S_PRD    = 14'b00001000000000,
        S_PCHK   = 14'b00010000000000,
        S_HOLD   = 14'b00100000000000,
        S_RESULT = 14'b01000000000000,
        S_CRD    = 14'b10000000000000
    } state_t;
endpackage

### design/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator with coalescing.
//
// Requests arrive on the s_axis channel as transactions: tuser is req_type
// (0 allocate, 1 free), tdata holds req_size and req_offset. Each request
// returns exactly one result transaction on m_axis: tdata holds
// result_offset and status. The user must write the heap limit on the cfg
// channel only while the block is idle; the block itself does not enforce it.
// The block serves one request at a time. It walks the block table held in
// a single-port memory, reading each visited entry and then checking it; a
// free that coalesces also shifts the table tail down, moving one entry at a
// time. The table memory read port sets the pace of the walk. The result
// sits in an output register; a new request is taken only after it has been
// delivered, so a stalled receiver holds the block.
// Reset clears the block count, the heap usage and the limit (to all ones);
// the table memory is not cleared, since only written entries are read.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // req_size[15:0], req_offset[35:16]
    input  logic        s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // result_offset[19:0], status[22:20]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data       // heap_limit
);
    import ffha_pkg::*;

    cmd_t cmd;
    stat_t stat;
    logic [1:0] rd_sel;
    logic [STAT_W-1:0] res_status, status;
    logic [ADDR_W-1:0] result_offset;
    logic [ADDR_W-1:0] limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= '1;
        else if (cfg_valid)
            limit_reg <= cfg_data;
    end

    ffha_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .stat(stat), .cmd(cmd), .rd_sel(rd_sel), .res_status(res_status)
    );

    ffha_datapath #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .rd_sel(rd_sel), .stat(stat),
        .req_type(s_axis_tuser), .req_size(s_axis_tdata[15:0]),
        .req_offset(s_axis_tdata[35:16]), .heap_limit(limit_reg),
        .res_status(res_status), .result_offset(result_offset), .status(status)
    );

    assign m_axis_tdata = {1'b0, status, result_offset};

`include "first_fit_heap_allocator_defines.svh"

    // A request is never accepted while a result waits to be taken.
    `FFHA_ASSERT_ALWAYS(a_no_overlap, !(s_axis_tready && m_axis_tvalid))
    // An accepted request produces no result in the next cycle.
    `FFHA_ASSERT_NEXT(a_not_instant, s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
endmodule

### design/ffha_datapath.sv
// Datapath of the heap allocator: block table memory, counters and compare logic.
module ffha_datapath #(
    parameter int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ffha_pkg::cmd_t              cmd,
    input  logic [1:0]                  rd_sel,
    output ffha_pkg::stat_t             stat,
    input  logic                        req_type,
    input  logic [ffha_pkg::SIZE_W-1:0] req_size,
    input  logic [ffha_pkg::ADDR_W-1:0] req_offset,
    input  logic [ffha_pkg::ADDR_W-1:0] heap_limit,
    input  logic [ffha_pkg::STAT_W-1:0] res_status,
    output logic [ffha_pkg::ADDR_W-1:0] result_offset,
    output logic [ffha_pkg::STAT_W-1:0] status
);
    import ffha_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [ADDR_W-1:0] HDR = ADDR_W'(HEADER_BYTES);

    logic [ADDR_W:0] mem [MAX_BLOCKS];   // {free, length}
    logic [ADDR_W:0] rdata_reg;
    logic [ADDR_W:0] hold_reg, hold_next; // current block while coalescing
    logic [CNT_W-1:0] idx_reg, idx_next, count_reg, count_next;
    logic [CNT_W-1:0] home_reg;           // index of the block being freed
    logic [ADDR_W-1:0] start_reg, start_next, used_reg, used_next;
    logic type_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] off_reg;
    logic [ADDR_W-1:0] res_off_reg, res_off_next;
    logic [STAT_W-1:0] status_reg;
    logic [CNT_W-1:0] rd_addr;
    logic we;
    logic [CNT_W-1:0] wa;
    logic [ADDR_W:0] wd;
    logic [ADDR_W+1:0] app_sum;
    logic [ADDR_W-1:0] merged;

    // rd_sel: 0 index, 1 index + 1, 2 index - 1
    always_comb
    begin
        unique case (rd_sel)
            2'd1:    rd_addr = idx_reg + CNT_W'(1);
            2'd2:    rd_addr = idx_reg - CNT_W'(1);
            default: rd_addr = idx_reg;
        endcase
    end

    assign merged = hold_reg[ADDR_W-1:0] + HDR + rdata_reg[ADDR_W-1:0];
    assign app_sum = {2'b00, used_reg} + {2'b00, HDR} + {6'd0, size_reg};

    always_comb
    begin
        we = 1'b0;
        wa = idx_reg;
        wd = rdata_reg;
        if (cmd.mark) begin
            we = 1'b1;
            wd = {cmd.mark_val, rdata_reg[ADDR_W-1:0]};
        end else if (cmd.append) begin
            we = 1'b1;
            wa = count_reg;
            wd = {1'b0, 4'd0, size_reg};
        end else if (cmd.merge_nxt) begin
            we = 1'b1;
            wd = {1'b1, merged};
        end else if (cmd.merge_prv) begin
            we = 1'b1;
            wa = idx_reg - CNT_W'(1);
            wd = {1'b1, rdata_reg[ADDR_W-1:0] + HDR + hold_reg[ADDR_W-1:0]};
        end else if (cmd.shift) begin
            we = 1'b1;
            wd = rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa[IDX_W-1:0]] <= wd;
        if (cmd.rd)
            rdata_reg <= mem[rd_addr[IDX_W-1:0]];
        if (cmd.load) begin
            type_reg <= req_type;
            size_reg <= req_size;
            off_reg  <= req_offset;
        end
        if (cmd.mark)
            home_reg <= idx_reg;
        hold_reg <= hold_next;
        if (cmd.save_res)
            status_reg <= res_status;
    end

    always_comb
    begin
        hold_next = hold_reg;
        if (cmd.mark)
            hold_next = {1'b1, rdata_reg[ADDR_W-1:0]};
        else if (cmd.merge_nxt)
            hold_next = {1'b1, merged};
    end

    always_comb
    begin
        idx_next = idx_reg;
        start_next = start_reg;
        count_next = count_reg;
        used_next = used_reg;
        res_off_next = res_off_reg;
        if (cmd.load) begin
            idx_next = '0;
            start_next = '0;
            res_off_next = '0;
        end
        if (cmd.advance) begin
            idx_next = idx_reg + CNT_W'(1);
            start_next = start_reg + HDR + rdata_reg[ADDR_W-1:0];
        end
        if (cmd.shift)
            idx_next = idx_reg + CNT_W'(1);
        if (cmd.set_back)
            idx_next = home_reg;
        if (cmd.set_drop)
            idx_next = idx_reg + CNT_W'(1);
        if (cmd.dec_count)
            count_next = count_reg - CNT_W'(1);
        if (cmd.mark && !type_reg)
            res_off_next = start_reg + HDR;
        if (cmd.append) begin
            count_next = count_reg + CNT_W'(1);
            res_off_next = used_reg + HDR;
            used_next = app_sum[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg <= '0;
            count_reg <= '0;
            used_reg <= '0;
            start_reg <= '0;
            res_off_reg <= '0;
        end else begin
            idx_reg <= idx_next;
            count_reg <= count_next;
            used_reg <= used_next;
            start_reg <= start_next;
            res_off_reg <= res_off_next;
        end
    end

    assign stat.is_free_req = type_reg;
    assign stat.zero_size   = (size_reg == '0);
    assign stat.null_off    = (off_reg == '0);
    assign stat.at_end      = (idx_reg >= count_reg);
    assign stat.fit         = rdata_reg[ADDR_W] &&
                              (rdata_reg[ADDR_W-1:0] >= {4'd0, size_reg});
    assign stat.hit         = ({1'b0, start_reg} + {1'b0, HDR}) == {1'b0, off_reg};
    assign stat.ent_free    = rdata_reg[ADDR_W];
    assign stat.can_append  = (count_reg < CNT_W'(MAX_BLOCKS)) &&
                              (app_sum <= {2'b00, heap_limit});
    assign stat.has_next    = ({1'b0, idx_reg} + (CNT_W+1)'(1)) < {1'b0, count_reg};
    assign stat.has_prev    = (idx_reg != '0);
    assign stat.shift_done  = ({1'b0, idx_reg} + (CNT_W+1)'(1)) >= {1'b0, count_reg};

    assign result_offset = res_off_reg;
    assign status = status_reg;
endmodule

### design/ffha_ctrl.sv
// Controller state machine of the heap allocator.
module ffha_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    input  ffha_pkg::stat_t             stat,
    output ffha_pkg::cmd_t              cmd,
    output logic [1:0]                  rd_sel,
    output logic [ffha_pkg::STAT_W-1:0] res_status
);
    import ffha_pkg::*;

    state_t state_reg, state_next;
    status_t st_reg, st_next;
    logic out_valid_reg, out_valid_next;
    logic did_next_reg, did_next_next; // merged with the successor

    assign in_ready = state_reg[0] && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign res_status = st_reg;

    always_comb
    begin
        state_next = state_reg;
        st_next = st_reg;
        out_valid_next = out_valid_reg;
        did_next_next = did_next_reg;
        cmd = '0;
        rd_sel = 2'd0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    cmd.load = 1'b1;
                    did_next_next = 1'b0;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                if (stat.is_free_req ? stat.null_off : stat.zero_size) begin
                    st_next = ST_NULL;
                    state_next = S_RESULT;
                end else if (stat.at_end) begin
                    if (stat.is_free_req) begin
                        st_next = ST_UNKNOWN;
                        state_next = S_RESULT;
                    end else
                        state_next = S_APPEND;
                end else begin
                    cmd.rd = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (!stat.is_free_req && stat.fit) begin
                    cmd.mark = 1'b1;
                    st_next = ST_OK;
                    state_next = S_RESULT;
                end else if (stat.is_free_req && stat.hit) begin
                    if (stat.ent_free) begin
                        st_next = ST_DOUBLE;
                        state_next = S_RESULT;
                    end else begin
                        cmd.mark = 1'b1;
                        cmd.mark_val = 1'b1;
                        st_next = ST_OK;
                        state_next = S_FMARK;
                    end
                end else begin
                    cmd.advance = 1'b1;
                    state_next = S_RD;
                end
            end
            S_APPEND: begin
                if (stat.can_append) begin
                    cmd.append = 1'b1;
                    st_next = ST_OK;
                end else
                    st_next = ST_OOM;
                state_next = S_RESULT;
            end
            S_FMARK: begin
                if (stat.has_next) begin
                    cmd.rd = 1'b1;
                    rd_sel = 2'd1;
                    state_next = S_NCHK;
                end else
                    state_next = S_PRD;
            end
            S_NCHK: begin
                if (stat.ent_free) begin
                    cmd.merge_nxt = 1'b1;
                    cmd.dec_count = 1'b1;
                    did_next_next = 1'b1;
                    cmd.set_drop = 1'b1;   // remove entry index+1
                    state_next = S_SHRD;
                end else
                    state_next = S_PRD;
            end
            S_SHRD: begin
                if (stat.at_end || stat.shift_done && stat.at_end) begin
                    // After the successor merge the predecessor is still to check.
                    if (did_next_reg)
                        state_next = S_CRD;
                    else
                        state_next = S_RESULT;
                end else begin
                    cmd.rd = 1'b1;
                    rd_sel = 2'd1;
                    state_next = S_SHWR;
                end
            end
            S_SHWR: begin
                cmd.shift = 1'b1;
                state_next = S_SHRD;
            end
            S_CRD: begin
                // Shift pass moved the index; return it to the freed block.
                cmd.set_back = 1'b1;
                state_next = S_PRD;
            end
            S_PRD: begin
                if (stat.has_prev) begin
                    cmd.rd = 1'b1;
                    rd_sel = 2'd2;
                    state_next = S_PCHK;
                end else
                    state_next = S_RESULT;
            end
            S_PCHK: begin
                if (stat.ent_free) begin
                    cmd.merge_prv = 1'b1;
                    cmd.dec_count = 1'b1;
                    state_next = S_HOLD;
                end else
                    state_next = S_RESULT;
            end
            S_HOLD: begin
                // Drop the freed entry: shift the tail down from its place.
                state_next = S_SHRD;
                did_next_next = 1'b0;
            end
            S_RESULT: begin
                if (!out_valid_reg || out_ready) begin
                    cmd.save_res = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            st_reg <= ST_OK;
            out_valid_reg <= 1'b0;
            did_next_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            st_reg <= st_next;
            out_valid_reg <= out_valid_next;
            did_next_reg <= did_next_next;
        end
    end
endmodule
